[rtl/sss_pkg.sv]
// shared types and constants for the separator stream splitter
// no dependencies; imported by every module of the block
package sss_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] REG_SEP_BYTES  = 1'd0;
  localparam logic [CfgIdxBits-1:0] REG_SEP_LENGTH = 1'd1;

  // configuration widths and reset values
  localparam int unsigned SepBytesBits = 64;
  localparam int unsigned SepLenBits   = 4;
  localparam logic [SepBytesBits-1:0] SEP_BYTES_RESET  = 64'd10;  // newline
  localparam logic [SepLenBits-1:0]   SEP_LENGTH_RESET = 4'd1;

  // result queue between front and back
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrBits  = 2;
  localparam int unsigned QCntBits  = 3;

  // one result word
  typedef struct packed {
    logic [31:0] len;
    logic [31:0] start;
    logic        fin;
  } chunk_t;

  // up to two result words pushed by the front in one cycle
  typedef struct packed {
    logic [1:0] n;
    chunk_t     c0;
    chunk_t     c1;
  } push_t;

endpackage

[rtl/sss_front.sv]
// front end: accepts bytes, keeps window, position and last chunk end,
// detects separator matches and forms chunk words; uses sss_pkg
module sss_front #(
  parameter int unsigned MAX_SEPARATOR = 8,
  parameter int unsigned OFFSET_BITS   = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sss_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [sss_pkg::SepBytesBits-1:0] cfg_data_i,
  input  logic                             accept_i,
  input  logic [7:0]                       data_byte_i,
  input  logic                             carries_byte_i,
  input  logic                             end_of_buffer_i,
  output sss_pkg::push_t                   push_o
);
  import sss_pkg::*;

  localparam int unsigned WinBits = MAX_SEPARATOR * 8;
  localparam logic [OFFSET_BITS-1:0] PosLimit = {OFFSET_BITS{1'b1}};

  logic [SepBytesBits-1:0] sep_bytes_q;
  logic [SepLenBits-1:0]   sep_len_q;
  logic [WinBits-1:0]      win_q, win_d, win_shift, tail;
  logic [OFFSET_BITS-1:0]  pos_q, pos_d, pos_next;
  logic [OFFSET_BITS-1:0]  last_q, last_d, last_mid;
  logic [SepLenBits-1:0]   eff_len;
  logic [6:0]              shift_amt;
  logic                    mismatch, match;
  chunk_t                  sep_chunk, tail_chunk;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_bytes_q <= SEP_BYTES_RESET;
      sep_len_q   <= SEP_LENGTH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SEP_BYTES) begin
        sep_bytes_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_SEP_LENGTH) begin
        sep_len_q <= cfg_data_i[SepLenBits-1:0];
      end
    end
  end

  // clamp separator length into 1..MAX_SEPARATOR
  always_comb begin
    if (sep_len_q == '0) begin
      eff_len = SepLenBits'(1);
    end else if (sep_len_q > SepLenBits'(MAX_SEPARATOR)) begin
      eff_len = SepLenBits'(MAX_SEPARATOR);
    end else begin
      eff_len = sep_len_q;
    end
  end

  // window shift and saturating position
  always_comb begin
    win_shift = win_q;
    pos_next  = pos_q;
    if (carries_byte_i) begin
      win_shift = (win_q >> 8) | (WinBits'(data_byte_i) << (WinBits - 8));
      if (pos_q != PosLimit) begin
        pos_next = pos_q + 1'b1;
      end
    end
  end

  // compare the newest eff_len bytes against the separator, byte by byte
  always_comb begin
    shift_amt = 7'((MAX_SEPARATOR - int'(eff_len)) * 8);
    tail      = win_shift >> shift_amt;
    mismatch  = 1'b0;
    for (int k = 0; k < MAX_SEPARATOR; k++) begin
      if ((k < int'(eff_len)) && (tail[k*8 +: 8] != sep_bytes_q[k*8 +: 8])) begin
        mismatch = 1'b1;
      end
    end
    match = carries_byte_i && !mismatch && (pos_next >= OFFSET_BITS'(eff_len));
  end

  // chunk words for a separator hit and for the buffer tail
  always_comb begin
    last_mid         = match ? pos_next : last_q;
    sep_chunk.start  = 32'(last_q);
    sep_chunk.len    = 32'(pos_next - last_q);
    sep_chunk.fin    = 1'b0;
    tail_chunk.start = 32'(last_mid);
    tail_chunk.len   = 32'(pos_next - last_mid);
    tail_chunk.fin   = 1'b1;
  end

  // push request toward the queue
  always_comb begin
    push_o.c0 = match ? sep_chunk : tail_chunk;
    push_o.c1 = tail_chunk;
    push_o.n  = 2'd0;
    if (accept_i) begin
      push_o.n = 2'({1'b0, match} + {1'b0, end_of_buffer_i});
    end
  end

  // next buffer state
  always_comb begin
    win_d  = win_shift;
    pos_d  = pos_next;
    last_d = last_mid;
    if (end_of_buffer_i) begin
      win_d  = '0;
      pos_d  = '0;
      last_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      pos_q  <= '0;
      last_q <= '0;
    end else if (accept_i) begin
      win_q  <= win_d;
      pos_q  <= pos_d;
      last_q <= last_d;
    end
  end

  // checks
  a_two_words_end_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n == 2'd2) |-> (push_o.c1.fin && !push_o.c0.fin))
    else $error("two words pushed without separator then tail");

  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_buffer_i) |=> (pos_q == '0 && last_q == '0))
    else $error("buffer state not cleared after end of buffer");

  a_last_not_past_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q <= pos_q)
    else $error("last chunk end beyond byte position");

endmodule

[rtl/sss_queue.sv]
// result queue: takes up to two chunk words per cycle from the front,
// hands one per cycle to the back when it pops; uses sss_pkg
module sss_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sss_pkg::push_t  push_i,
  output logic            room_o,
  input  logic            pop_i,
  output logic            avail_o,
  output sss_pkg::chunk_t head_o
);
  import sss_pkg::*;

  chunk_t              entry_q [QDepth];
  logic [QPtrBits-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_inc;
  logic [QCntBits-1:0] cnt_q, cnt_d;
  logic                do_pop;

  assign room_o     = cnt_q <= QCntBits'(QDepth - 2);
  assign avail_o    = cnt_q != '0;
  assign head_o     = entry_q[rd_ptr_q];
  assign do_pop     = pop_i && avail_o;
  assign wr_ptr_inc = wr_ptr_q + 1'b1;
  assign cnt_d      = cnt_q + QCntBits'(push_i.n) - QCntBits'(do_pop);

  // storage writes, second word goes one slot after the first
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.c0;
    end
    if (push_i.n == 2'd2) begin
      entry_q[wr_ptr_inc] <= push_i.c1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrBits'(push_i.n);
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // checks
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> (cnt_q + QCntBits'(push_i.n) <= QCntBits'(QDepth)))
    else $error("push into full queue");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntBits'(QDepth))
    else $error("queue count out of range");

  a_cnt_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n == 2'd0 && !do_pop) |=> $stable(cnt_q))
    else $error("queue count moved without push or pop");

endmodule

[rtl/sss_back.sv]
// back end: output register that drives the master stream from the queue
// uses sss_pkg
module sss_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  sss_pkg::chunk_t head_i,
  output logic            pop_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [63:0]     m_axis_tdata,
  output logic            m_axis_tlast
);
  import sss_pkg::*;

  logic   valid_q;
  chunk_t word_q;
  logic   load;

  assign load  = !valid_q || m_axis_tready;
  assign pop_o = load && avail_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= avail_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= head_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {word_q.len, word_q.start};
  assign m_axis_tlast  = word_q.fin;

  // checks
  a_pop_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("popped word not presented");

  a_pop_needs_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> avail_i)
    else $error("pop from empty queue");

  a_drain_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && m_axis_tready && !avail_i) |=> !valid_q)
    else $error("word repeated after it was taken");

endmodule

[rtl/separator_stream_splitter.sv]
// top level of the separator stream splitter: front, result queue, back
// depends on sss_pkg, sss_front, sss_queue, sss_back
//
//  channel  dir  width        contents
//  s_axis   in   8 + 1 + 1    tdata: data_byte; tuser: carries_byte; tlast: end_of_buffer
//  m_axis   out  64 + 1       tdata: chunk_start, chunk_length; tlast: final_chunk
//  cfg      in   1 + 64       index 0 separator_bytes, index 1 separator_length
//
// one input word per cycle while the queue has room; a word turns into zero,
// one or two chunk words, and the output side delivers one chunk word per cycle
// while m_axis_tready is high, so a buffer end that closes on a separator yields two words
// match, position update and chunk forming finish in the cycle a word is taken
// a four-entry queue parts the front from the output register; the input
// stalls only while fewer than two queue slots are free
// reset clears window, position, last chunk end, queue and output valid
module separator_stream_splitter #(
  parameter int unsigned MAX_SEPARATOR = 8,
  parameter int unsigned OFFSET_BITS   = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [sss_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [sss_pkg::SepBytesBits-1:0] cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] data_byte
  input  logic                             s_axis_tuser,   // [0] carries_byte
  input  logic                             s_axis_tlast,
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [63:0]                      m_axis_tdata,   // [31:0] chunk_start, [63:32] chunk_length
  output logic                             m_axis_tlast
);
  import sss_pkg::*;

  push_t  push;
  chunk_t head;
  logic   room, avail, pop, accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  sss_front #(
    .MAX_SEPARATOR(MAX_SEPARATOR),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .data_byte_i    (s_axis_tdata),
    .carries_byte_i (s_axis_tuser),
    .end_of_buffer_i(s_axis_tlast),
    .push_o         (push)
  );

  sss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .pop_i  (pop),
    .avail_o(avail),
    .head_o (head)
  );

  sss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (avail),
    .head_i       (head),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
